// ===== design/stt_pkg.sv =====
// Shared types and codes for the software timer table.
package stt_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_FIRED  = 3'd1;
    localparam logic [2:0] KIND_ADD    = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_QUERY  = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] target_id;
        logic        new_kind;
        logic        new_loop;
        logic [31:0] new_time;
        logic [15:0] tick_delta_ms;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [31:0] out_id;
        logic [31:0] out_value;
        logic        out_trig_kind;
        logic        out_loop;
        logic        found;
        logic        last_result;
    } rsp_t;

    // One timer entry as it moves along the row.
    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic        kind;
        logic        loop;
        logic [31:0] tval;
        logic [31:0] elapsed;
    } entry_t;

    // Operation broadcast to every cell.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_APPEND
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== design/stt_cell.sv =====
// One timer slot: holds an entry and shifts it toward its lower neighbor.
module stt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  stt_pkg::cell_op_t   op,
    input  logic                prev_valid,
    input  stt_pkg::entry_t     from_up,
    input  stt_pkg::entry_t     tail_in,
    input  stt_pkg::entry_t     new_entry,
    output stt_pkg::entry_t     entry
);

    logic            valid_reg;
    logic [31:0]     id_reg;
    logic            kind_reg;
    logic            loop_reg;
    logic [31:0]     tval_reg;
    logic [31:0]     elapsed_reg;
    stt_pkg::entry_t entry_cur;
    stt_pkg::entry_t entry_next;

    always_comb
    begin
        entry_cur.valid   = valid_reg;
        entry_cur.id      = id_reg;
        entry_cur.kind    = kind_reg;
        entry_cur.loop    = loop_reg;
        entry_cur.tval    = tval_reg;
        entry_cur.elapsed = elapsed_reg;
    end

    always_comb
    begin
        entry_next = entry_cur;
        case (op)
            stt_pkg::OP_ROTATE:
            begin
                // advance the live prefix; the last live cell takes the word from the head
                if (from_up.valid)
                begin
                    entry_next = from_up;
                end
                else if (entry_cur.valid)
                begin
                    entry_next = tail_in;
                end
            end
            stt_pkg::OP_APPEND:
            begin
                if (!entry_cur.valid && prev_valid)
                begin
                    entry_next = new_entry;
                end
            end
            default:
            begin
                entry_next = entry_cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= entry_next.id;
        kind_reg    <= entry_next.kind;
        loop_reg    <= entry_next.loop;
        tval_reg    <= entry_next.tval;
        elapsed_reg <= entry_next.elapsed;
    end

    assign entry = entry_cur;

endmodule

// ===== design/software_timer_table.sv =====
// Top level of the software timer table: a rotating row of timer cells.
//
//   channel   | handshake      | payload
//   ----------+----------------+-----------------------
//   request   | start / busy   | req (stt_pkg::req_t)
//   result    | rsp_valid      | rsp (stt_pkg::rsp_t)
//
// Tick, remove and query rotate the live prefix once, one timer per cycle
// at the head cell: IDLE accepts the request, SCAN visits each of the n live
// timers (at most NUM_TIMERS) and DONE closes it. An add goes from IDLE to DONE.
// Dropped entries leave the row as it turns; survivors keep their order.
// Results are registered and shown for one cycle each; a tick word is held
// back one step so the final word can be flagged. The last word of a request
// shows in the first cycle busy is low. Reset empties the table and clears
// the id counter. The receiver cannot stall results.
module software_timer_table #(
    parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  stt_pkg::req_t req,
    output logic          busy,
    output logic          rsp_valid,
    output stt_pkg::rsp_t rsp
);

    localparam int CW = $clog2(NUM_TIMERS + 1);

    stt_pkg::state_t state_reg, state_next;
    stt_pkg::req_t   req_reg, req_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   num_reg, num_next;
    logic [31:0]     idc_reg, idc_next;
    logic            hit_reg, hit_next;
    stt_pkg::entry_t hit_e_reg, hit_e_next;
    logic            pend_v_reg, pend_v_next;
    stt_pkg::rsp_t   pend_reg, pend_next;
    logic            rv_reg, rv_next;
    stt_pkg::rsp_t   rsp_reg, rsp_next;

    stt_pkg::cell_op_t op;
    stt_pkg::entry_t   ent [NUM_TIMERS];
    stt_pkg::entry_t   tail_in;
    stt_pkg::entry_t   new_e;
    stt_pkg::entry_t   head;
    logic [32:0]       esum;
    logic [31:0]       esat;
    logic              fire, drop, full;
    logic [CW-1:0]     live;

    assign head = ent[0];
    assign full = ent[NUM_TIMERS-1].valid;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            stt_pkg::entry_t up;
            logic            prev_v;
            if (g == NUM_TIMERS - 1)
            begin : g_t
                assign up = '0;
            end
            else
            begin : g_m
                assign up = ent[g+1];
            end
            if (g == 0)
            begin : g_first
                assign prev_v = 1'b1;
            end
            else
            begin : g_rest
                assign prev_v = ent[g-1].valid;
            end
            stt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .prev_valid (prev_v),
                .from_up    (up),
                .tail_in    (tail_in),
                .new_entry  (new_e),
                .entry      (ent[g])
            );
        end
    endgenerate

    always_comb
    begin
        live = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            live = live + CW'(ent[i].valid);
        end
    end

    always_comb
    begin
        esum = {1'b0, head.elapsed} + {17'd0, req_reg.tick_delta_ms};
        esat = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
        if (!head.kind)
        begin
            fire = esat >= head.tval;
            drop = fire && !head.loop;
        end
        else
        begin
            fire = req_reg.now_seconds >= head.tval;
            drop = fire;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        idc_next    = idc_reg;
        hit_next    = hit_reg;
        hit_e_next  = hit_e_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        rv_next     = 1'b0;
        rsp_next    = rsp_reg;
        op          = stt_pkg::OP_HOLD;
        tail_in     = head;
        new_e          = '0;
        new_e.valid    = 1'b1;
        new_e.id       = idc_reg + 32'd1;
        new_e.kind     = req.new_kind;
        new_e.loop     = req.new_kind ? 1'b0 : req.new_loop;
        new_e.tval     = req.new_time;
        new_e.elapsed  = 32'd0;
        case (state_reg)
            stt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    cnt_next = '0;
                    num_next = live;
                    hit_next = 1'b0;
                    if (req.req_type == stt_pkg::REQ_ADD)
                    begin
                        // append in place; answer in the closing cycle
                        op          = stt_pkg::OP_APPEND;
                        state_next  = stt_pkg::ST_DONE;
                        pend_v_next = 1'b1;
                        pend_next   = '0;
                        pend_next.out_kind = stt_pkg::KIND_ADD;
                        if (!full)
                        begin
                            idc_next         = idc_reg + 32'd1;
                            pend_next.out_id = idc_reg + 32'd1;
                            pend_next.found  = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = (live == '0) ? stt_pkg::ST_DONE : stt_pkg::ST_SCAN;
                        if (req.req_type == stt_pkg::REQ_TICK)
                        begin
                            pend_v_next = 1'b1;
                            pend_next   = '0;
                            pend_next.out_kind  = stt_pkg::KIND_TICK;
                            pend_next.out_value = {16'd0, req.tick_delta_ms};
                        end
                    end
                end
            end
            stt_pkg::ST_SCAN:
            begin
                op       = stt_pkg::OP_ROTATE;
                cnt_next = cnt_reg + CW'(1);
                tail_in  = head;
                case (req_reg.req_type)
                    stt_pkg::REQ_TICK:
                    begin
                        tail_in.elapsed = fire ? 32'd0 : esat;
                        if (drop)
                        begin
                            tail_in.valid = 1'b0;
                        end
                        if (fire)
                        begin
                            // release the held word; hold the fired one
                            rv_next     = pend_v_reg;
                            rsp_next    = pend_reg;
                            pend_v_next = 1'b1;
                            pend_next   = '0;
                            pend_next.out_kind      = stt_pkg::KIND_FIRED;
                            pend_next.out_id        = head.id;
                            pend_next.out_value     = esat;
                            pend_next.out_trig_kind = head.kind;
                            pend_next.out_loop      = head.loop;
                        end
                    end
                    default:
                    begin
                        if (!hit_reg && head.id == req_reg.target_id)
                        begin
                            hit_next   = 1'b1;
                            hit_e_next = head;
                            if (req_reg.req_type == stt_pkg::REQ_REMOVE)
                            begin
                                tail_in.valid = 1'b0;
                            end
                        end
                    end
                endcase
                if (cnt_reg == num_reg - CW'(1))
                begin
                    state_next = stt_pkg::ST_DONE;
                end
            end
            stt_pkg::ST_DONE:
            begin
                state_next = stt_pkg::ST_IDLE;
                rv_next    = 1'b1;
                if (pend_v_reg)
                begin
                    pend_v_next = 1'b0;
                    rsp_next    = pend_reg;
                    rsp_next.last_result = 1'b1;
                end
                else
                begin
                    rsp_next = '0;
                    rsp_next.last_result = 1'b1;
                    rsp_next.out_id      = req_reg.target_id;
                    case (req_reg.req_type)
                        stt_pkg::REQ_REMOVE:
                        begin
                            rsp_next.out_kind = stt_pkg::KIND_REMOVE;
                            rsp_next.found    = hit_reg;
                        end
                        default:
                        begin
                            rsp_next.out_kind = stt_pkg::KIND_QUERY;
                            if (hit_reg)
                            begin
                                rsp_next.found         = 1'b1;
                                rsp_next.out_value     = hit_e_reg.tval;
                                rsp_next.out_trig_kind = hit_e_reg.kind;
                                rsp_next.out_loop      = hit_e_reg.loop;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = stt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stt_pkg::ST_IDLE;
            cnt_reg    <= '0;
            num_reg    <= '0;
            idc_reg    <= '0;
            hit_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            num_reg    <= num_next;
            idc_reg    <= idc_next;
            hit_reg    <= hit_next;
            pend_v_reg <= pend_v_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        hit_e_reg <= hit_e_next;
        pend_reg  <= pend_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;
    assign busy      = (state_reg != stt_pkg::ST_IDLE);

endmodule
